/* design/sfd_pkg.sv */
package sfd_pkg;

	localparam int FRAME_LEN = 17;
	localparam int CSUM_LEN  = 14;
	localparam int CNT_W     = $clog2(FRAME_LEN);

	localparam logic [7:0] SYNC_BYTE = 8'h7F;
	localparam logic [7:0] END_CR    = 8'h0D;
	localparam logic [7:0] END_LF    = 8'h0A;

	localparam logic [8:0]  TEMP_OFFSET    = 9'd40;
	localparam logic [11:0] EXHAUST_OFFSET = 12'd40;

	localparam int OUT_DATA_W = 104;

	typedef enum logic {
		STATUS_OK        = 1'b0,
		STATUS_CSUM_FAIL = 1'b1
	} frame_status_t;

	// bytes 0 to 14 of a matched frame; the trailer is not needed past the match
	typedef logic [CSUM_LEN:0][7:0] frame_bytes_t;

	typedef struct packed {
		logic [15:0]        engine_speed;
		logic [15:0]        throttle_tenths;
		logic signed [8:0]  cylinder_temp;
		logic signed [11:0] exhaust_temp;
		logic [15:0]        fuel_pressure;
		logic signed [8:0]  rotor_temp;
		logic signed [8:0]  intake_temp;
		logic [7:0]         intake_pressure;
		logic [7:0]         supply_tenths_volt;
	} engine_fields_t;

	function automatic logic signed [8:0] temp_from_byte(input logic [7:0] b);
		return $signed({b[7], b}) - $signed(TEMP_OFFSET);
	endfunction

endpackage

/* design/sensor_frame_deframer.sv */
// channel  dir  tdata                  tuser
// s_axis   in   [7:0] rx_byte          -
// m_axis   out  decoded engine fields  [0] frame_status
//
// One byte per cycle in; the closing byte sets frame_valid_s1, and the decoded result is then registered at m_axis.
// The 17-byte window is a shift line with a fill count; match is checked as
// the last byte arrives, checksum and scaling run in the stage after.
// Reset clears the fill count and both valid flags; byte contents are not reset.
// Input stalls only while a decoded frame waits behind a stalled output.
module sensor_frame_deframer (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [15:0] engine_speed, [31:16] throttle_tenths, [40:32] cylinder_temp,
	// [52:41] exhaust_temp, [68:53] fuel_pressure, [77:69] rotor_temp,
	// [86:78] intake_temp, [94:87] intake_pressure, [102:95] supply_tenths_volt
	output logic [sfd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic [0:0]   m_axis_tuser    // [0] frame_status
);

	logic                    frame_valid_s1;
	logic                    frame_ready;
	sfd_pkg::frame_bytes_t   frame_s1;
	sfd_pkg::frame_status_t  status_q;
	sfd_pkg::engine_fields_t fields_q;

	sfd_window u_window (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.in_byte        (s_axis_tdata),
		.frame_valid_s1 (frame_valid_s1),
		.frame_ready    (frame_ready),
		.frame_s1       (frame_s1)
	);

	sfd_decode u_decode (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_valid_s1 (frame_valid_s1),
		.frame_ready    (frame_ready),
		.frame_s1       (frame_s1),
		.out_valid_q    (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.status_q       (status_q),
		.fields_q       (fields_q)
	);

	assign m_axis_tuser = status_q;
	assign m_axis_tdata = {1'b0,
	                       fields_q.supply_tenths_volt,
	                       fields_q.intake_pressure,
	                       fields_q.intake_temp,
	                       fields_q.rotor_temp,
	                       fields_q.fuel_pressure,
	                       fields_q.exhaust_temp,
	                       fields_q.cylinder_temp,
	                       fields_q.throttle_tenths,
	                       fields_q.engine_speed};

endmodule

/* design/sfd_window.sv */
module sfd_window (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	output logic                  frame_valid_s1,
	input  logic                  frame_ready,
	output sfd_pkg::frame_bytes_t frame_s1
);

	logic [7:0]                 win_q [sfd_pkg::FRAME_LEN];
	logic [sfd_pkg::CNT_W-1:0]  count_q;
	logic                       accept;
	logic                       full_now;
	logic                       marks_ok;

	assign in_ready = !frame_valid_s1 || frame_ready;
	assign accept   = in_valid && in_ready;

	// window becomes full with this word; newest byte lands at the top
	assign full_now = (count_q == sfd_pkg::CNT_W'(sfd_pkg::FRAME_LEN - 1));
	assign marks_ok = (win_q[1] == sfd_pkg::SYNC_BYTE) && (win_q[2] == sfd_pkg::SYNC_BYTE) &&
	                  (win_q[sfd_pkg::FRAME_LEN-1] == sfd_pkg::END_CR) &&
	                  (in_byte == sfd_pkg::END_LF);

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < sfd_pkg::FRAME_LEN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[sfd_pkg::FRAME_LEN-1] <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (!full_now) begin
				count_q <= count_q + sfd_pkg::CNT_W'(1);
			end else if (marks_ok) begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_s1 <= 1'b0;
		end else if (accept && full_now && marks_ok) begin
			frame_valid_s1 <= 1'b1;
		end else if (frame_ready) begin
			frame_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && full_now && marks_ok) begin
			for (int i = 0; i <= sfd_pkg::CSUM_LEN; i++) begin
				frame_s1[i] <= win_q[i+1];
			end
		end
	end

endmodule

/* design/sfd_decode.sv */
module sfd_decode (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   frame_valid_s1,
	output logic                   frame_ready,
	input  sfd_pkg::frame_bytes_t  frame_s1,
	output logic                   out_valid_q,
	input  logic                   out_ready,
	output sfd_pkg::frame_status_t status_q,
	output sfd_pkg::engine_fields_t fields_q
);

	logic [7:0]               l1 [7];
	logic [7:0]               l2 [4];
	logic [7:0]               l3 [2];
	logic [7:0]               csum;
	logic [11:0]              exh_x5;
	logic                     load;
	sfd_pkg::engine_fields_t  dec;

	assign frame_ready = !out_valid_q || out_ready;
	assign load        = frame_valid_s1 && frame_ready;

	always_comb begin
		for (int i = 0; i < 7; i++) begin
			l1[i] = frame_s1[2*i] + frame_s1[2*i+1];
		end
		for (int i = 0; i < 3; i++) begin
			l2[i] = l1[2*i] + l1[2*i+1];
		end
		l2[3] = l1[6];
		l3[0] = l2[0] + l2[1];
		l3[1] = l2[2] + l2[3];
		csum  = l3[0] + l3[1];
	end

	assign exh_x5 = {2'b00, frame_s1[7], 2'b00} + {4'b0000, frame_s1[7]};

	always_comb begin
		dec                    = '0;
		dec.engine_speed       = {frame_s1[3], frame_s1[2]};
		dec.throttle_tenths    = {frame_s1[5], frame_s1[4]};
		dec.cylinder_temp      = sfd_pkg::temp_from_byte(frame_s1[6]);
		dec.exhaust_temp       = $signed(exh_x5 - sfd_pkg::EXHAUST_OFFSET);
		dec.fuel_pressure      = {frame_s1[9], frame_s1[8]};
		dec.rotor_temp         = sfd_pkg::temp_from_byte(frame_s1[10]);
		dec.intake_temp        = sfd_pkg::temp_from_byte(frame_s1[11]);
		dec.intake_pressure    = frame_s1[12];
		dec.supply_tenths_volt = frame_s1[13];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (csum == frame_s1[sfd_pkg::CSUM_LEN]) begin
				status_q <= sfd_pkg::STATUS_OK;
				fields_q <= dec;
			end else begin
				status_q <= sfd_pkg::STATUS_CSUM_FAIL;
				fields_q <= '0;
			end
		end
	end

endmodule
